// ===== rtl/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants of the method trial sequencer
// Sizes of the trial tables, the radix of the average divider, the command
// and status bundles between controller and datapath, and the item layouts.
// ----------------------------------------------------------------------------
package mts_pkg;

	// Table sizes and trial policy
	localparam int MAX_METHODS    = 8;
	localparam int NUM_TESTS      = 4;
	localparam int TIME_BITS      = 32;
	localparam int SUM_BITS       = TIME_BITS + 8;
	localparam int IDX_BITS       = 3;
	localparam int COUNT_BITS     = 4;   // method_count register and scan pointer
	localparam int START_BITS     = 4;
	localparam int REPORT_BITS    = 5;
	localparam int REPORT_MAX     = 31;
	localparam int MIN_INIT       = 999999;

	// Average divider: one quotient digit of DIV_DIGIT_BITS per cycle
	localparam int DIV_DIGIT_BITS = 4;
	localparam int DIV_STEPS      = SUM_BITS / DIV_DIGIT_BITS;
	localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

	// Configuration port
	localparam int CFG_IDX_BITS   = 1;
	localparam int CFG_DATA_BITS  = 8;

	// Stream widths
	localparam int IN_TDATA_BITS  = 72;
	localparam int OUT_TDATA_BITS = 104;

	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_REPORT  = 1'b1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_METHOD_COUNT = 1'b0,
		REG_DUAL_MASK    = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_START,
		ST_SCAN_REPORT,
		ST_REP_CHECK,
		ST_REP_SUM,
		ST_DIV,
		ST_REP_AVG,
		ST_REP_DONE,
		ST_FINISH
	} state_t;

	// How the pending result register is loaded
	typedef enum logic [2:0] {
		RES_HOLD,
		RES_CLAIM,
		RES_WAIT,
		RES_DONE,
		RES_ZERO,
		RES_STATS
	} res_sel_t;

	typedef struct packed {
		logic     take;
		logic     ptr_load;
		logic     ptr_inc;
		logic     time_calc;
		logic     sum_update;
		logic     div_step;
		logic     avg_write;
		res_sel_t res_sel;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic perf;
		logic idx_bad;
		logic ptr_end;
		logic start_open;
		logic report_open;
		logic div_last;
	} dp_status_t;

	// Input item without the command, first field in the lowest bits
	typedef struct packed {
		logic [TIME_BITS-1:0] end_time;
		logic [TIME_BITS-1:0] start_time;
		logic                 perf_flag;
		logic [IDX_BITS-1:0]  method_index;
	} in_item_t;

	// Result item, first field in the lowest bits
	typedef struct packed {
		logic [TIME_BITS-1:0] method_maximum;
		logic [TIME_BITS-1:0] method_minimum;
		logic [TIME_BITS-1:0] method_average;
		logic                 measure_flag;
		logic                 eval_done;
		logic [IDX_BITS-1:0]  chosen_method;
	} res_item_t;

endpackage

// ===== rtl/method_trial_sequencer.sv =====
// ----------------------------------------------------------------------------
// method_trial_sequencer: trial scheduler for up to eight candidate methods
// Hands out the next method to time and folds reported run times into
// per-method sum, average, minimum and maximum.
// ----------------------------------------------------------------------------
// A request (tuser 0) returns the first method at or after the remembered
// scan position that has been started fewer than four times, with the
// measure flag set; once all are started it repeats the remembered method
// with the flag clear until every method from that position on has all its
// reports in (dual-block methods need eight), then answers eval_done. A
// report (tuser 1) returns the method's statistics, updated first when
// perf_flag is set. One item is worked on at a time, and the next is taken
// while a finished result waits on the output. The table scan of a request
// visits one method per cycle, once for start counts and, when all are
// started, once more for report counts. A report skips the divider when the
// index is out of range or perf_flag is clear; otherwise the digit-serial
// divider forms the average one 4-bit quotient digit per cycle over the
// 40-bit sum. Configuration writes belong to idle periods.
// ----------------------------------------------------------------------------
module method_trial_sequencer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [mts_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [mts_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	// request stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// method_index[2:0], perf_flag[3], start_time[35:4], end_time[67:36]
	input  logic [mts_pkg::IN_TDATA_BITS-1:0]    s_tdata,
	// cmd[0]
	input  logic                                 s_tuser,
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// chosen_method[2:0], eval_done[3], measure_flag[4], method_average[36:5],
	// method_minimum[68:37], method_maximum[100:69]
	output logic [mts_pkg::OUT_TDATA_BITS-1:0]   m_tdata
);

	// Commands from the sequencer, status back from the tables
	mts_pkg::dp_cmd_t    cmd;
	mts_pkg::dp_status_t status;

	// Sequencer: handshakes, scan and report steps
	mts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Tables, statistics, divider and result registers
	mts_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== rtl/mts_ctrl.sv =====
// ----------------------------------------------------------------------------
// mts_ctrl: sequencing state machine
// Walks a request through the two table scans and a report through the
// time, sum, divide and write steps; owns the stream handshakes.
// ----------------------------------------------------------------------------
module mts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  mts_pkg::dp_status_t status,
	output mts_pkg::dp_cmd_t    cmd
);

	mts_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign s_tready = (state_q == mts_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mts_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_sel = mts_pkg::RES_HOLD;
		case (state_q)
			mts_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take     = 1'b1;
					cmd.ptr_load = 1'b1;
					state_d = (s_tuser == mts_pkg::CMD_REPORT) ? mts_pkg::ST_REP_CHECK
					                                           : mts_pkg::ST_SCAN_START;
				end
			end
			mts_pkg::ST_SCAN_START: begin
				if (status.ptr_end) begin
					cmd.ptr_load = 1'b1;
					state_d = mts_pkg::ST_SCAN_REPORT;
				end else if (status.start_open) begin
					cmd.res_sel = mts_pkg::RES_CLAIM;
					state_d = mts_pkg::ST_FINISH;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			mts_pkg::ST_SCAN_REPORT: begin
				if (status.ptr_end) begin
					cmd.res_sel = mts_pkg::RES_DONE;
					state_d = mts_pkg::ST_FINISH;
				end else if (status.report_open) begin
					cmd.res_sel = mts_pkg::RES_WAIT;
					state_d = mts_pkg::ST_FINISH;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			mts_pkg::ST_REP_CHECK: begin
				cmd.time_calc = 1'b1;
				if (status.idx_bad) begin
					cmd.res_sel = mts_pkg::RES_ZERO;
					state_d = mts_pkg::ST_FINISH;
				end else if (!status.perf) begin
					cmd.res_sel = mts_pkg::RES_STATS;
					state_d = mts_pkg::ST_FINISH;
				end else begin
					state_d = mts_pkg::ST_REP_SUM;
				end
			end
			mts_pkg::ST_REP_SUM: begin
				cmd.sum_update = 1'b1;
				state_d = mts_pkg::ST_DIV;
			end
			mts_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = mts_pkg::ST_REP_AVG;
				end
			end
			mts_pkg::ST_REP_AVG: begin
				cmd.avg_write = 1'b1;
				state_d = mts_pkg::ST_REP_DONE;
			end
			mts_pkg::ST_REP_DONE: begin
				cmd.res_sel = mts_pkg::RES_STATS;
				state_d = mts_pkg::ST_FINISH;
			end
			mts_pkg::ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = mts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mts_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/mts_datapath.sv =====
// ----------------------------------------------------------------------------
// mts_datapath: trial tables, statistics and average divider
// Holds the per-method counters and timing statistics, the scan pointer,
// the digit-serial divider and the pending and output result registers.
// ----------------------------------------------------------------------------
module mts_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mts_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [mts_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic [mts_pkg::IN_TDATA_BITS-1:0]     s_tdata,
	input  mts_pkg::dp_cmd_t                      cmd,
	output mts_pkg::dp_status_t                   status,
	output logic [mts_pkg::OUT_TDATA_BITS-1:0]    m_tdata
);

	localparam int TB = mts_pkg::TIME_BITS;
	localparam int SB = mts_pkg::SUM_BITS;
	localparam int DB = mts_pkg::DIV_DIGIT_BITS;
	localparam int WB = mts_pkg::START_BITS;

	// Configuration
	logic [mts_pkg::COUNT_BITS-1:0] method_count_q;
	logic [7:0]                     dual_mask_q;

	// Per-method tables
	logic [WB-1:0]                   start_cnt_q [mts_pkg::MAX_METHODS];
	logic [mts_pkg::REPORT_BITS-1:0] rpt_cnt_q   [mts_pkg::MAX_METHODS];
	logic [SB-1:0]                   sum_q       [mts_pkg::MAX_METHODS];
	logic [TB-1:0]                   avg_q       [mts_pkg::MAX_METHODS];
	logic [TB-1:0]                   min_q       [mts_pkg::MAX_METHODS];
	logic [TB-1:0]                   max_q       [mts_pkg::MAX_METHODS];
	logic [mts_pkg::IDX_BITS-1:0]    scan_start_q;
	logic [mts_pkg::COUNT_BITS-1:0]  ptr_q;

	// Latched item and report working registers
	mts_pkg::in_item_t               item_q;
	logic [TB-1:0]                   t_q;
	logic [SB-1:0]                   dq_q;
	logic [WB-1:0]                   rem_q;
	logic [WB-1:0]                   dvs_q;
	logic [mts_pkg::DIV_CNT_BITS-1:0] dcnt_q;
	mts_pkg::res_item_t              res_q;
	mts_pkg::res_item_t              out_q;

	logic [mts_pkg::COUNT_BITS-1:0]  n_eff;
	logic [mts_pkg::IDX_BITS-1:0]    ptr_idx;
	logic [mts_pkg::IDX_BITS-1:0]    idx;
	logic [mts_pkg::REPORT_BITS-1:0] need;
	logic [SB:0]                     sum_ext;
	logic [SB-1:0]                   sum_new;
	logic [WB-1:0]                   rem_n;
	logic [WB:0]                     part;
	logic [DB-1:0]                   qdig;

	assign n_eff = (method_count_q > mts_pkg::COUNT_BITS'(mts_pkg::MAX_METHODS))
	             ? mts_pkg::COUNT_BITS'(mts_pkg::MAX_METHODS) : method_count_q;
	assign ptr_idx = ptr_q[mts_pkg::IDX_BITS-1:0];
	assign idx     = item_q.method_index;
	assign need    = dual_mask_q[ptr_idx] ? mts_pkg::REPORT_BITS'(2 * mts_pkg::NUM_TESTS)
	                                      : mts_pkg::REPORT_BITS'(mts_pkg::NUM_TESTS);

	assign status.perf        = item_q.perf_flag;
	assign status.idx_bad     = mts_pkg::COUNT_BITS'(idx) >= n_eff;
	assign status.ptr_end     = ptr_q >= n_eff;
	assign status.start_open  = start_cnt_q[ptr_idx] < WB'(mts_pkg::NUM_TESTS);
	assign status.report_open = rpt_cnt_q[ptr_idx] < need;
	assign status.div_last    = dcnt_q == mts_pkg::DIV_CNT_BITS'(mts_pkg::DIV_STEPS - 1);

	// Saturating sum update
	assign sum_ext = {1'b0, sum_q[idx]} + (SB + 1)'(t_q);
	assign sum_new = sum_ext[SB] ? '1 : sum_ext[SB-1:0];

	// One radix-16 quotient digit: four restoring steps on a narrow remainder
	always_comb begin
		rem_n = rem_q;
		part  = '0;
		qdig  = '0;
		for (int k = 0; k < DB; k++) begin
			part = {rem_n, dq_q[SB-1-k]};
			if (part >= {1'b0, dvs_q}) begin
				part = part - {1'b0, dvs_q};
				qdig[DB-1-k] = 1'b1;
			end
			rem_n = part[WB-1:0];
		end
	end

	// Configuration, tables and scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_count_q <= mts_pkg::COUNT_BITS'(8);
			dual_mask_q    <= '0;
			scan_start_q   <= '0;
			for (int i = 0; i < mts_pkg::MAX_METHODS; i++) begin
				start_cnt_q[i] <= '0;
				rpt_cnt_q[i]   <= '0;
				sum_q[i]       <= '0;
				avg_q[i]       <= '0;
				min_q[i]       <= TB'(mts_pkg::MIN_INIT);
				max_q[i]       <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (mts_pkg::cfg_reg_t'(cfg_index))
					mts_pkg::REG_METHOD_COUNT: method_count_q <= cfg_data[mts_pkg::COUNT_BITS-1:0];
					mts_pkg::REG_DUAL_MASK:    dual_mask_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.res_sel == mts_pkg::RES_CLAIM) begin
				start_cnt_q[ptr_idx] <= start_cnt_q[ptr_idx] + WB'(1);
				scan_start_q         <= ptr_idx;
			end
			if (cmd.sum_update) begin
				sum_q[idx] <= sum_new;
				if (t_q > max_q[idx]) begin
					max_q[idx] <= t_q;
				end
				if (t_q < min_q[idx]) begin
					min_q[idx] <= t_q;
				end
				if (rpt_cnt_q[idx] < mts_pkg::REPORT_BITS'(mts_pkg::REPORT_MAX)) begin
					rpt_cnt_q[idx] <= rpt_cnt_q[idx] + mts_pkg::REPORT_BITS'(1);
				end
			end
			if (cmd.avg_write) begin
				if (dvs_q == '0) begin
					avg_q[idx] <= '0;
				end else if (|dq_q[SB-1:TB]) begin
					avg_q[idx] <= '1;
				end else begin
					avg_q[idx] <= dq_q[TB-1:0];
				end
			end
		end
	end

	// Working registers and results
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= mts_pkg::in_item_t'(s_tdata[$bits(mts_pkg::in_item_t)-1:0]);
		end
		if (cmd.ptr_load) begin
			ptr_q <= mts_pkg::COUNT_BITS'(scan_start_q);
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + mts_pkg::COUNT_BITS'(1);
		end
		if (cmd.time_calc) begin
			t_q <= item_q.end_time - item_q.start_time;
		end
		if (cmd.sum_update) begin
			dq_q   <= sum_new;
			rem_q  <= '0;
			dvs_q  <= start_cnt_q[idx];
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dq_q   <= {dq_q[SB-DB-1:0], qdig};
			rem_q  <= rem_n;
			dcnt_q <= dcnt_q + mts_pkg::DIV_CNT_BITS'(1);
		end
		case (cmd.res_sel)
			mts_pkg::RES_CLAIM: begin
				res_q               <= '0;
				res_q.chosen_method <= ptr_idx;
				res_q.measure_flag  <= 1'b1;
			end
			mts_pkg::RES_WAIT: begin
				res_q               <= '0;
				res_q.chosen_method <= scan_start_q;
			end
			mts_pkg::RES_DONE: begin
				res_q           <= '0;
				res_q.eval_done <= 1'b1;
			end
			mts_pkg::RES_ZERO: begin
				res_q <= '0;
			end
			mts_pkg::RES_STATS: begin
				res_q                <= '0;
				res_q.method_average <= avg_q[idx];
				res_q.method_minimum <= min_q[idx];
				res_q.method_maximum <= max_q[idx];
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign m_tdata = mts_pkg::OUT_TDATA_BITS'(out_q);

endmodule

// ===== verif/tb_method_trial_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_method_trial_sequencer: self-checking bench for the trial sequencer
// Drives scheduling and report requests over the input stream, predicts
// every result with a tracker that mirrors the trial tables, and compares
// each returned result field by field under changing idling patterns,
// register settings and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_method_trial_sequencer;
	import mts_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 24;     // longer than the slowest report
	localparam int HOLDOFF_CYCLES = 300;

	// Mirror of the trial tables: predicts the result of each accepted request
	// and holds the results still owed by the block, oldest first.
	class trial_tracker;
		localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_BITS) - 1;
		localparam longint unsigned TIME_LIMIT = (64'd1 << TIME_BITS) - 1;

		logic [3:0] method_count;
		logic [7:0] dual_mask;
		logic [START_BITS-1:0] starts[MAX_METHODS];
		logic [REPORT_BITS-1:0] reports[MAX_METHODS];
		logic [SUM_BITS-1:0] sums[MAX_METHODS];
		logic [TIME_BITS-1:0] averages[MAX_METHODS];
		logic [TIME_BITS-1:0] minimums[MAX_METHODS];
		logic [TIME_BITS-1:0] maximums[MAX_METHODS];
		logic [IDX_BITS-1:0] scan_pos;
		res_item_t answers_due[$];
		int errors;

		function new();
			method_count = 4'd8;
			dual_mask = 8'h00;
			scan_pos = '0;
			errors = 0;
			for (int i = 0; i < MAX_METHODS; i++) begin
				starts[i] = '0;
				reports[i] = '0;
				sums[i] = '0;
				averages[i] = '0;
				minimums[i] = MIN_INIT;
				maximums[i] = '0;
			end
		endfunction

		function int active_methods();
			return (method_count > MAX_METHODS) ? MAX_METHODS : int'(method_count);
		endfunction

		function int pending();
			return answers_due.size();
		endfunction

		function void write_reg(cfg_reg_t r, logic [7:0] v);
			if (r == REG_METHOD_COUNT)
				method_count = v[3:0];
			else
				dual_mask = v;
		endfunction

		// Update the tables for one accepted request and queue its result
		function void take_command(logic cmd, in_item_t it);
			res_item_t r;
			int n;
			int i;
			int need;
			bit found;
			logic [TIME_BITS-1:0] run_time;
			longint unsigned s;
			longint unsigned avg;
			r = '0;
			n = active_methods();
			if (cmd == CMD_REQUEST) begin
				found = 1'b0;
				for (i = int'(scan_pos); i < n; i++) begin
					if (!found && starts[i] < NUM_TESTS) begin
						starts[i]++;
						scan_pos = i[IDX_BITS-1:0];
						found = 1'b1;
					end
				end
				if (found) begin
					r.chosen_method = scan_pos;
					r.measure_flag = 1'b1;
				end else begin
					// all started: wait on the remembered method while reports lag
					r.eval_done = 1'b1;
					for (i = int'(scan_pos); i < n; i++) begin
						need = dual_mask[i] ? 2 * NUM_TESTS : NUM_TESTS;
						if (reports[i] < need) begin
							r.eval_done = 1'b0;
							r.chosen_method = scan_pos;
						end
					end
				end
			end else if (it.method_index < n) begin
				if (it.perf_flag) begin
					run_time = it.end_time - it.start_time;
					s = 64'(sums[it.method_index]) + 64'(run_time);
					if (s > SUM_LIMIT)
						s = SUM_LIMIT;
					sums[it.method_index] = SUM_BITS'(s);
					avg = (starts[it.method_index] != 0)
						? s / 64'(starts[it.method_index]) : 64'd0;
					averages[it.method_index] = TIME_BITS'((avg > TIME_LIMIT) ? TIME_LIMIT : avg);
					if (run_time > maximums[it.method_index])
						maximums[it.method_index] = run_time;
					if (run_time < minimums[it.method_index])
						minimums[it.method_index] = run_time;
					if (reports[it.method_index] < REPORT_MAX)
						reports[it.method_index]++;
				end
				r.method_average = averages[it.method_index];
				r.method_minimum = minimums[it.method_index];
				r.method_maximum = maximums[it.method_index];
			end
			answers_due.push_back(r);
		endfunction

		function void check_field(string name, logic [TIME_BITS-1:0] want,
				logic [TIME_BITS-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void match_answer(res_item_t got);
			res_item_t want;
			if (answers_due.size() == 0) begin
				$error("result with nothing outstanding: %h", got);
				errors++;
				return;
			end
			want = answers_due.pop_front();
			check_field("chosen_method", TIME_BITS'(want.chosen_method),
				TIME_BITS'(got.chosen_method));
			check_field("eval_done", TIME_BITS'(want.eval_done), TIME_BITS'(got.eval_done));
			check_field("measure_flag", TIME_BITS'(want.measure_flag),
				TIME_BITS'(got.measure_flag));
			check_field("method_average", want.method_average, got.method_average);
			check_field("method_minimum", want.method_minimum, got.method_minimum);
			check_field("method_maximum", want.method_maximum, got.method_maximum);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_BITS-1:0] s_tdata = '0;    // method_index, perf_flag, start, end
	logic s_tuser = 1'b0;                      // cmd
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;        // chosen, done, flag, avg, min, max

	trial_tracker tracker = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int cycle_count = 0;

	method_trial_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	// Hard stop: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL method_trial_sequencer");
			$finish;
		end
	end

	// Result side: hold off while a long stall is pending, else stall at random
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Check every result at the edge where it is taken
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_answer(m_tdata[$bits(res_item_t)-1:0]);
	end

	// Offer one request, idling first at random; return at the accepting edge
	task automatic send(logic cmd, logic [IDX_BITS-1:0] idx, logic perf,
			logic [TIME_BITS-1:0] t0, logic [TIME_BITS-1:0] t1);
		in_item_t it;
		it.method_index = idx;
		it.perf_flag = perf;
		it.start_time = t0;
		it.end_time = t1;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= IN_TDATA_BITS'(it);
		do @(posedge clk); while (!s_tready);
		tracker.take_command(cmd, it);
	endtask

	// Random request; with focus set, reports pile maximal run times on one method
	task automatic send_random(int req_pct, int focus);
		logic cmd;
		logic [IDX_BITS-1:0] idx;
		logic perf;
		logic [TIME_BITS-1:0] t0;
		logic [TIME_BITS-1:0] t1;
		int n;
		n = tracker.active_methods();
		cmd = ($urandom_range(99) < req_pct) ? CMD_REQUEST : CMD_REPORT;
		idx = IDX_BITS'($urandom);
		// keep most reports on methods in use; the rest take any index, some out of range
		if (n > 0 && $urandom_range(99) < 85)
			idx = IDX_BITS'($urandom_range(n - 1));
		perf = ($urandom_range(99) < 85);
		t0 = $urandom;
		case ($urandom_range(4))
			0: t1 = t0 + $urandom_range(2000000);   // around the initial minimum
			1: t1 = $urandom;
			2: t1 = t0 - 1;                         // longest run time
			3: t1 = t0;                             // zero run time
			default: t1 = t0 + $urandom_range(20);  // repeats equal times often
		endcase
		if (focus >= 0 && cmd == CMD_REPORT) begin
			idx = IDX_BITS'(focus);
			perf = 1'b1;
			t1 = t0 - 1;
		end
		send(cmd, idx, perf, t0, t1);
	endtask

	// Drop valid and wait for every owed result
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		tracker.write_reg(r, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: two methods, method 1 dual-block; upper count bits ignored
		write_reg(REG_METHOD_COUNT, 8'h32);
		write_reg(REG_DUAL_MASK, 8'h02);
		send(CMD_REPORT, 3'd0, 1'b1, 32'h0, 32'h0);                    // zero starts, zero time
		send(CMD_REPORT, 3'd1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE);   // longest time
		send(CMD_REPORT, 3'd2, 1'b1, 32'd5, 32'd10);                  // index out of range
		send(CMD_REPORT, 3'd7, 1'b0, 32'hFFFF_FFFF, 32'h0);           // out of range, no perf
		send(CMD_REPORT, 3'd1, 1'b0, 32'd0, 32'd3);                   // perf clear: no update
		repeat (8)
			send(CMD_REQUEST, IDX_BITS'($urandom), 1'($urandom), $urandom,
				$urandom);                                            // four starts each
		send(CMD_REQUEST, 3'd5, 1'b1, 32'hFFFF_FFFF, 32'h0);          // reports outstanding
		repeat (3)
			send(CMD_REPORT, 3'd1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
		send(CMD_REQUEST, 3'd0, 1'b0, 32'h0, 32'h0);                  // dual needs eight
		send(CMD_REPORT, 3'd1, 1'b1, 32'h1234_5678, 32'h1234_5677);   // average saturates
		send(CMD_REPORT, 3'd1, 1'b1, 32'hFFFF_FFFE, 32'h1);           // wraps to 3, new min
		send(CMD_REPORT, 3'd1, 1'b1, 32'd10, 32'd13);                 // equal to minimum
		send(CMD_REPORT, 3'd1, 1'b1, 32'd0, 32'd1000000);
		send(CMD_REQUEST, 3'd2, 1'b1, 32'd1, 32'd2);                  // now done
		drain();

		// Five methods, dual-block on the last one; sender idles often
		write_reg(REG_METHOD_COUNT, 8'h05);
		write_reg(REG_DUAL_MASK, 8'h10);
		send_idle_pct = 75;
		repeat (120)
			send_random(40, -1);
		drain();

		// No methods in use: every request answers done, every report is ignored
		write_reg(REG_METHOD_COUNT, 8'h00);
		send_idle_pct = 0;
		stall_pct = 75;
		repeat (12)
			send_random(50, -1);
		drain();

		// Count beyond range saturates to eight, all methods dual-block
		write_reg(REG_METHOD_COUNT, 8'hFF);
		write_reg(REG_DUAL_MASK, 8'hFF);
		send_idle_pct = 37;
		stall_pct = 37;
		repeat (20)
			send_random(40, -1);
		// hold the output while requests keep coming, so the input backs up
		hold_cycles = HOLDOFF_CYCLES;
		repeat (180)
			send_random(40, -1);
		drain();

		// Scan position now past the method count: requests answer done
		write_reg(REG_METHOD_COUNT, 8'h03);
		write_reg(REG_DUAL_MASK, 8'h00);
		send_idle_pct = 0;
		stall_pct = 75;
		repeat (60)
			send_random(40, -1);
		drain();

		// Pile longest run times on one method until its sum saturates
		write_reg(REG_METHOD_COUNT, 8'h08);
		write_reg(REG_DUAL_MASK, 8'h80);
		stall_pct = 0;
		hold_cycles = HOLDOFF_CYCLES;
		repeat (320)
			send_random(20, 6);
		drain();

		// Single method, then an over-range count with no dual-block bits
		write_reg(REG_METHOD_COUNT, 8'h01);
		write_reg(REG_DUAL_MASK, 8'h01);
		send_idle_pct = 37;
		stall_pct = 37;
		repeat (80)
			send_random(40, -1);
		drain();

		write_reg(REG_METHOD_COUNT, 8'h09);
		write_reg(REG_DUAL_MASK, 8'h00);
		send_idle_pct = 75;
		stall_pct = 0;
		repeat (80)
			send_random(40, -1);
		drain();

		write_reg(REG_METHOD_COUNT, 8'h08);
		write_reg(REG_DUAL_MASK, 8'h55);
		send_idle_pct = 0;
		repeat (60)
			send_random(40, -1);
		drain();

		// Catch any stray result after the last one owed
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("PASS method_trial_sequencer");
		else
			$display("FAIL method_trial_sequencer");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mts_pkg.sv
rtl/mts_ctrl.sv
rtl/mts_datapath.sv
rtl/method_trial_sequencer.sv
verif/tb_method_trial_sequencer.sv
